[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// When pre holds at one edge, post must hold at the next.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[hdl/cdq_pkg.sv]
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [2:0] {
        FUNC_FRONT_PUSH = 3'd0,
        FUNC_BACK_PUSH  = 3'd1,
        FUNC_FRONT_POP  = 3'd2,
        FUNC_BACK_POP   = 3'd3,
        FUNC_READ       = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] value;
        logic [3:0]         position;
    } cdq_in_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] data;
        logic [4:0]         occupancy;
    } cdq_out_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic  shift_back;   // front push: every element moves one place back
        logic  shift_front;  // front pop: every element moves one place forward
        logic  load_back;    // back push: the cell just past the last one loads
        idx_t  back_idx;
        data_t value;
    } cdq_cell_ctrl_t;

endpackage

[hdl/cdq_cell.sv]
`timescale 1ns / 1ps

module cdq_cell (
    input  logic                   aclk,
    input  cdq_pkg::cdq_cell_ctrl_t ctrl,
    input  cdq_pkg::idx_t          cell_idx,
    input  cdq_pkg::data_t         prev_data,
    input  cdq_pkg::data_t         next_data,
    output cdq_pkg::data_t         data_o
);
    import cdq_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_back) begin
            data_next = prev_data;
        end else if (ctrl.shift_front) begin
            data_next = next_data;
        end else if (ctrl.load_back && (ctrl.back_idx == cell_idx)) begin
            data_next = ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;

endmodule

[hdl/circular_deque.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Double-ended queue of 16 32-bit elements held as a row of cells, cell 0 at the
// front. Each item pushes at the front or the back, pops from either end, or reads
// the element at a position from the front, and gives exactly one result: status,
// data and the new occupancy. At the edge that accepts an item a front push or pop
// shifts the whole row and a back push loads one cell; the result sits in the output
// register from the next cycle on. s_ready is high out of reset whenever that register
// is empty or being taken, so items flow at one per cycle when m_ready stays high. Full
// pushes, empty pops and reads at or beyond the occupancy leave the queue unchanged
// and return an error status with zero data.
module circular_deque (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cdq_pkg::cdq_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output cdq_pkg::cdq_out_t m_item
);
    import cdq_pkg::*;

    cnt_t           count_reg;
    cnt_t           count_next;
    logic           m_valid_reg;
    logic           m_valid_next;
    cdq_out_t       m_item_reg;
    cdq_out_t       m_item_next;
    cdq_cell_ctrl_t ctrl;
    status_t        status;
    logic           want_data;
    idx_t           rd_sel;
    data_t          rd_data;
    data_t          cell_data [DEPTH];
    cnt_t           count_m1;
    logic           s_fire;
    logic           full;
    logic           empty;

    assign s_ready  = aresetn && (!m_valid_reg || m_ready);
    assign s_fire   = s_valid && s_ready;
    assign full     = (count_reg == cnt_t'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - 1'b1;

    // Operation decode
    always_comb begin
        ctrl            = '0;
        ctrl.value      = data_t'(s_item.value);
        ctrl.back_idx   = count_reg[IDX_W-1:0];
        status          = STAT_OK;
        want_data       = 1'b0;
        rd_sel          = '0;
        count_next      = count_reg;
        unique case (s_item.func)
            FUNC_FRONT_PUSH: begin
                if (full) begin
                    status = STAT_FULL;
                end else begin
                    ctrl.shift_back = s_fire;
                    count_next      = count_reg + 1'b1;
                end
            end
            FUNC_BACK_PUSH: begin
                if (full) begin
                    status = STAT_FULL;
                end else begin
                    ctrl.load_back = s_fire;
                    count_next     = count_reg + 1'b1;
                end
            end
            FUNC_FRONT_POP: begin
                if (empty) begin
                    status = STAT_EMPTY;
                end else begin
                    ctrl.shift_front = s_fire;
                    want_data        = 1'b1;
                    count_next       = count_m1;
                end
            end
            FUNC_BACK_POP: begin
                if (empty) begin
                    status = STAT_EMPTY;
                end else begin
                    want_data  = 1'b1;
                    rd_sel     = count_m1[IDX_W-1:0];
                    count_next = count_m1;
                end
            end
            FUNC_READ: begin
                if (cnt_t'(s_item.position) >= count_reg) begin
                    status = STAT_RANGE;
                end else begin
                    want_data = 1'b1;
                    rd_sel    = idx_t'(s_item.position);
                end
            end
            default: begin
            end
        endcase
    end

    assign rd_data = cell_data[rd_sel];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        data_t prev_d;
        data_t next_d;
        if (i == 0) begin : g_first
            assign prev_d = ctrl.value;
        end else begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign next_d = cell_data[i];
        end else begin : g_mid_next
            assign next_d = cell_data[i+1];
        end
        cdq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .cell_idx  (idx_t'(i)),
            .prev_data (prev_d),
            .next_data (next_d),
            .data_o    (cell_data[i])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (s_fire) begin
            m_valid_next          = 1'b1;
            m_item_next.status    = status;
            m_item_next.data      = want_data ? 32'(rd_data) : '0;
            m_item_next.occupancy = 5'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ASSERT_AT(a_count_bound, count_reg <= cnt_t'(DEPTH), "occupancy above depth")
    `ASSERT_NEXT(a_front_push_lands, s_fire && s_item.func == FUNC_FRONT_PUSH && !full,
        cell_data[0] == data_t'($past(s_item.value)), "front push did not reach cell 0")
    `ASSERT_NEXT(a_occ_tracks, s_fire, m_valid_reg && m_item_reg.occupancy == 5'(count_reg),
        "result occupancy differs from stored count")

endmodule
